// ----- sv/nsr_pkg.sv -----
// ----------------------------------------------------------------------------
// NMEA sentence receiver package
// Shared constants, event codes and the result record of the receiver.
// ----------------------------------------------------------------------------
package nsr_pkg;

  localparam int DEF_MAX_FIELD_LEN = 64;
  localparam int DEF_MAX_FIELDS    = 32;

  localparam int EVENT_W = 3;
  localparam int BYTE_W  = 8;
  localparam int FIDX_W  = 5;
  localparam int CIDX_W  = 6;

  // event codes
  localparam logic [EVENT_W-1:0] EV_STRAY   = 3'd0;
  localparam logic [EVENT_W-1:0] EV_START   = 3'd1;
  localparam logic [EVENT_W-1:0] EV_CHAR    = 3'd2;
  localparam logic [EVENT_W-1:0] EV_COMMA   = 3'd3;
  localparam logic [EVENT_W-1:0] EV_STAR    = 3'd4;
  localparam logic [EVENT_W-1:0] EV_NO_CSUM = 3'd5;
  localparam logic [EVENT_W-1:0] EV_CSUM_OK = 3'd6;
  localparam logic [EVENT_W-1:0] EV_CSUM_ER = 3'd7;

  // characters
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

  typedef struct packed {
    logic [EVENT_W-1:0] event_res;
    logic [BYTE_W-1:0]  byte_out;
    logic [FIDX_W-1:0]  field_index;
    logic [CIDX_W-1:0]  char_index;
    logic               field_overflow;
    logic [BYTE_W-1:0]  computed_checksum;
  } nsr_result_t;

  // upper-case ASCII hex digit of a nibble
  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
    logic [BYTE_W-1:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

// ----- sv/nsr_parser.sv -----
// ----------------------------------------------------------------------------
// NMEA sentence parser
// Sentence state machine, running checksum and field/char counters; builds
// the result for one byte in a single pass.
// ----------------------------------------------------------------------------
module nsr_parser #(
  parameter int MAX_FIELD_LEN = nsr_pkg::DEF_MAX_FIELD_LEN,
  parameter int MAX_FIELDS    = nsr_pkg::DEF_MAX_FIELDS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  logic [7:0]             byte_in,
  output logic                   has_res,
  output nsr_pkg::nsr_result_t   res
);
  import nsr_pkg::*;

  localparam int FC_W = $clog2(MAX_FIELDS);
  localparam int CC_W = $clog2(MAX_FIELD_LEN + 1);
  localparam int FX_W = (FC_W > FIDX_W) ? FC_W : FIDX_W;
  localparam int CX_W = (CC_W > CIDX_W) ? CC_W : CIDX_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FIELDS = 3'd1;
  localparam logic [2:0] ST_CS_HI  = 3'd2;
  localparam logic [2:0] ST_CS_LO  = 3'd3;
  localparam logic [2:0] ST_SKIP   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [BYTE_W-1:0] csum_r, csum_nxt;
  logic [FC_W-1:0]   fcnt_r, fcnt_nxt;
  logic [CC_W-1:0]   ccnt_r, ccnt_nxt;
  logic              ovf_r, ovf_nxt;

  logic              eol;
  logic [FX_W-1:0]   fcnt_ext;
  logic [FIDX_W-1:0] fidx_cap;
  logic [CC_W-1:0]   pos;
  logic [CX_W-1:0]   pos_ext;
  logic [CIDX_W-1:0] pos_cap;

  assign eol      = (byte_in == CH_CR) || (byte_in == CH_LF);
  assign fcnt_ext = FX_W'(fcnt_r);
  assign fidx_cap = (fcnt_ext > FX_W'(31)) ? 5'd31 : fcnt_ext[FIDX_W-1:0];
  assign pos      = (ccnt_r >= CC_W'(MAX_FIELD_LEN)) ? CC_W'(MAX_FIELD_LEN - 1) : ccnt_r;
  assign pos_ext  = CX_W'(pos);
  assign pos_cap  = (pos_ext > CX_W'(63)) ? 6'd63 : pos_ext[CIDX_W-1:0];

  always_comb begin
    state_nxt = state_r;
    csum_nxt  = csum_r;
    fcnt_nxt  = fcnt_r;
    ccnt_nxt  = ccnt_r;
    ovf_nxt   = ovf_r;
    has_res   = 1'b1;
    res.event_res         = EV_STRAY;
    res.byte_out          = byte_in;
    res.field_index       = fidx_cap;
    res.char_index        = '0;
    res.field_overflow    = ovf_r;
    res.computed_checksum = csum_r;
    unique case (state_r)
      ST_FIELDS: begin
        if (byte_in == CH_COMMA) begin
          csum_nxt = csum_r ^ byte_in;
          if (fcnt_r == FC_W'(MAX_FIELDS - 1)) begin
            ovf_nxt = 1'b1;
          end else begin
            fcnt_nxt = fcnt_r + 1'b1;
          end
          ccnt_nxt = '0;
          res.event_res         = EV_COMMA;
          res.field_overflow    = ovf_nxt;
          res.computed_checksum = csum_nxt;
        end else if (byte_in == CH_STAR) begin
          state_nxt     = ST_CS_HI;
          res.event_res = EV_STAR;
        end else if (eol) begin
          state_nxt     = ST_IDLE;
          res.event_res = EV_NO_CSUM;
        end else begin
          if (ccnt_r >= CC_W'(MAX_FIELD_LEN)) begin
            ovf_nxt = 1'b1;
          end else begin
            ccnt_nxt = ccnt_r + 1'b1;
          end
          csum_nxt = csum_r ^ byte_in;
          res.event_res         = EV_CHAR;
          res.char_index        = pos_cap;
          res.field_overflow    = ovf_nxt;
          res.computed_checksum = csum_nxt;
        end
      end
      ST_CS_HI: begin
        if (eol) begin
          state_nxt     = ST_IDLE;
          res.event_res = EV_CSUM_ER;
        end else if (byte_in == hex_char(csum_r[7:4])) begin
          // first digit good: wait silently for the second
          state_nxt = ST_CS_LO;
          has_res   = 1'b0;
        end else begin
          state_nxt     = ST_SKIP;
          res.event_res = EV_CSUM_ER;
        end
      end
      ST_CS_LO: begin
        state_nxt     = ST_IDLE;
        res.event_res = (byte_in == hex_char(csum_r[3:0])) ? EV_CSUM_OK : EV_CSUM_ER;
      end
      ST_SKIP: begin
        state_nxt = ST_IDLE;
        has_res   = 1'b0;
      end
      default: begin
        res.field_index       = '0;
        res.field_overflow    = 1'b0;
        res.computed_checksum = '0;
        if (byte_in == CH_DOLLAR) begin
          state_nxt     = ST_FIELDS;
          csum_nxt      = '0;
          fcnt_nxt      = '0;
          ccnt_nxt      = '0;
          ovf_nxt       = 1'b0;
          res.event_res = EV_START;
        end else begin
          state_nxt     = ST_IDLE;
          res.event_res = EV_STRAY;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      csum_r  <= '0;
      fcnt_r  <= '0;
      ccnt_r  <= '0;
      ovf_r   <= 1'b0;
    end else if (fire) begin
      state_r <= state_nxt;
      csum_r  <= csum_nxt;
      fcnt_r  <= fcnt_nxt;
      ccnt_r  <= ccnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ----- sv/nsr_out_reg.sv -----
// ----------------------------------------------------------------------------
// NMEA sentence receiver output register
// Holds one result transaction and tells the input side when it may load.
// ----------------------------------------------------------------------------
module nsr_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  nsr_pkg::nsr_result_t res,
  input  logic                 out_stall,
  output logic                 ready,
  output logic                 out_valid,
  output nsr_pkg::nsr_result_t out_res
);
  import nsr_pkg::*;

  logic        valid_r;
  nsr_result_t res_r;

  // free when empty or draining this cycle
  assign ready     = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      res_r <= res;
    end
  end

endmodule

// ----- sv/nmea_sentence_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// NMEA sentence receiver
// Parses an NMEA 0183 byte stream and streams field characters, field ends
// and checksum verdicts as result transactions.
// ----------------------------------------------------------------------------
//   channel  | direction | payload
//   in_      | input     | byte_in
//   out_     | output    | event_res, byte_out, field_index, char_index,
//            |           | field_overflow, computed_checksum
//
// One byte per cycle unless stalled: each byte is parsed in one pass from the
// state registers into the output register, so a result appears in the cycle
// after its byte is taken. Some bytes (good first checksum digit, skipped byte)
// give no result. in_stall rises only while the output register holds a
// result and out_stall is high. Reset is synchronous; the machine starts idle.
module nmea_sentence_receiver_unit #(
  parameter int MAX_FIELD_LEN = nsr_pkg::DEF_MAX_FIELD_LEN,
  parameter int MAX_FIELDS    = nsr_pkg::DEF_MAX_FIELDS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [nsr_pkg::BYTE_W-1:0]   in_byte_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [nsr_pkg::EVENT_W-1:0]  out_event_res,
  output logic [nsr_pkg::BYTE_W-1:0]   out_byte_out,
  output logic [nsr_pkg::FIDX_W-1:0]   out_field_index,
  output logic [nsr_pkg::CIDX_W-1:0]   out_char_index,
  output logic                         out_field_overflow,
  output logic [nsr_pkg::BYTE_W-1:0]   out_computed_checksum
);
  import nsr_pkg::*;

  logic        ready;
  logic        fire;
  logic        has_res;
  nsr_result_t res;
  nsr_result_t out_res;

  assign in_stall = !ready;
  assign fire     = in_valid && ready;

  nsr_parser #(
    .MAX_FIELD_LEN(MAX_FIELD_LEN),
    .MAX_FIELDS   (MAX_FIELDS)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .byte_in(in_byte_in),
    .has_res(has_res),
    .res    (res)
  );

  nsr_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire && has_res),
    .res      (res),
    .out_stall(out_stall),
    .ready    (ready),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  assign out_event_res         = out_res.event_res;
  assign out_byte_out          = out_res.byte_out;
  assign out_field_index       = out_res.field_index;
  assign out_char_index        = out_res.char_index;
  assign out_field_overflow    = out_res.field_overflow;
  assign out_computed_checksum = out_res.computed_checksum;

endmodule
